>>> design/bms_pkg.sv
package bms_pkg;

	localparam int unsigned BMS_AGE_WIDTH = 16;
	localparam int unsigned BMS_CFG_WIDTH = 16;

	localparam logic [BMS_CFG_WIDTH-1:0] BMS_DEBOUNCE_RESET   = 16'd50;
	localparam logic [BMS_CFG_WIDTH-1:0] BMS_LONG_PRESS_RESET = 16'd500;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_CW    = 2'd1,
		MODE_VOICE = 2'd2
	} mode_t;

	typedef enum logic {
		SEL_CW    = 1'b0,
		SEL_VOICE = 1'b1
	} sel_t;

	typedef enum logic {
		REG_DEBOUNCE   = 1'b0,
		REG_LONG_PRESS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		mode_t mode;
		sel_t  chosen;
		logic  changed;
	} bms_result_t;

	function automatic mode_t mode_of_sel(input sel_t sel);
		mode_t m;
		unique case (sel)
			SEL_CW:    m = MODE_CW;
			SEL_VOICE: m = MODE_VOICE;
			default:   m = MODE_CW;
		endcase
		return m;
	endfunction

endpackage

>>> design/bms_ctrl.sv
module bms_ctrl
	import bms_pkg::*;
#(
	parameter int unsigned AGE_WIDTH = BMS_AGE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     raw,
	input  logic [BMS_CFG_WIDTH-1:0] debounce_ticks,
	input  logic [BMS_CFG_WIDTH-1:0] long_press_ticks,
	output bms_result_t              result
);

	localparam int unsigned CMP_W = (AGE_WIDTH > BMS_CFG_WIDTH) ? AGE_WIDTH : BMS_CFG_WIDTH;

	logic                 stable_q;
	logic                 last_raw_q;
	logic                 long_done_q;
	logic [AGE_WIDTH-1:0] change_age_q;
	logic [AGE_WIDTH-1:0] press_age_q;
	mode_t                mode_q;
	sel_t                 sel_q;

	logic [AGE_WIDTH-1:0] change_age_d;
	logic [AGE_WIDTH-1:0] press_age_d;
	logic                 stable_d;
	logic                 long_done_mid;
	logic                 long_done_d;
	logic                 deb_hit;
	logic                 long_hit;
	mode_t                mode_mid;
	mode_t                mode_d;
	mode_t                mode_long;
	sel_t                 sel_d;
	logic                 changed_mid;
	logic                 changed_d;

	always_comb begin
		change_age_d = (&change_age_q) ? change_age_q : change_age_q + AGE_WIDTH'(1);
		press_age_d  = (&press_age_q) ? press_age_q : press_age_q + AGE_WIDTH'(1);
		if (raw != last_raw_q) begin
			change_age_d = '0;
		end

		deb_hit = (raw != stable_q) &&
			(CMP_W'(change_age_d) >= CMP_W'(debounce_ticks));
		stable_d      = deb_hit ? raw : stable_q;
		long_done_mid = long_done_q;
		mode_mid      = mode_q;
		changed_mid   = 1'b0;
		if (deb_hit && raw) begin
			press_age_d   = '0;
			long_done_mid = 1'b0;
		end else if (deb_hit && !long_done_q) begin
			mode_mid    = (mode_q == MODE_OFF) ? mode_of_sel(sel_q) : MODE_OFF;
			changed_mid = 1'b1;
		end

		long_hit = stable_d && !long_done_mid &&
			(CMP_W'(press_age_d) >= CMP_W'(long_press_ticks));
		sel_d       = sel_q;
		mode_d      = mode_mid;
		changed_d   = changed_mid;
		long_done_d = long_done_mid;
		mode_long   = mode_of_sel(sel_t'(~sel_q));
		if (long_hit) begin
			sel_d       = sel_t'(~sel_q);
			long_done_d = 1'b1;
			if (mode_mid != MODE_OFF && mode_long != mode_mid) begin
				mode_d    = mode_long;
				changed_d = 1'b1;
			end
		end

		result.mode    = mode_d;
		result.chosen  = sel_d;
		result.changed = changed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q     <= 1'b0;
			last_raw_q   <= 1'b0;
			long_done_q  <= 1'b0;
			change_age_q <= '0;
			press_age_q  <= '0;
			mode_q       <= MODE_OFF;
			sel_q        <= SEL_CW;
		end else if (step) begin
			stable_q     <= stable_d;
			last_raw_q   <= raw;
			long_done_q  <= long_done_d;
			change_age_q <= change_age_d;
			press_age_q  <= press_age_d;
			mode_q       <= mode_d;
			sel_q        <= sel_d;
		end
	end

endmodule

>>> design/button_mode_selector.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    btn_level
// out       output     out_valid / out_ready  current_mode, chosen_mode, stream_reset
// cfg       input      wr_en                  wr_index, wr_data
//
// One tick per cycle unless out_ready stalls: the state update is one combinational pass.
// The result is registered and valid in the cycle after the input transaction.
// in_ready is high whenever the result register is empty or being drained this cycle.
// Reset clears state, mode off, selection cw, debounce 50 and long press 500.
module button_mode_selector
	import bms_pkg::*;
#(
	parameter int unsigned AGE_WIDTH = BMS_AGE_WIDTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     btn_level,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               current_mode,
	output logic                     chosen_mode,
	output logic                     stream_reset,
	input  logic                     wr_en,
	input  logic                     wr_index,
	input  logic [BMS_CFG_WIDTH-1:0] wr_data
);

	logic [BMS_CFG_WIDTH-1:0] debounce_q;
	logic [BMS_CFG_WIDTH-1:0] long_press_q;
	logic                     out_valid_q;
	bms_result_t              result;
	bms_result_t              result_q;
	logic                     step;

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= BMS_DEBOUNCE_RESET;
			long_press_q <= BMS_LONG_PRESS_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_DEBOUNCE:   debounce_q   <= wr_data;
				REG_LONG_PRESS: long_press_q <= wr_data;
				default:        debounce_q   <= debounce_q;
			endcase
		end
	end

	bms_ctrl #(
		.AGE_WIDTH(AGE_WIDTH)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.raw              (btn_level),
		.debounce_ticks   (debounce_q),
		.long_press_ticks (long_press_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_valid    = out_valid_q;
	assign current_mode = result_q.mode;
	assign chosen_mode  = result_q.chosen;
	assign stream_reset = result_q.changed;

endmodule
